>>> rtl/rbs_pkg.sv
// Shared types and constants for the retry backoff scheduler.
package rbs_pkg;

   localparam int TABLE_DEPTH_DEF = 16;

   localparam int MODE_W    = 4;
   localparam int VALUE_W   = 17;
   localparam int SLOT_W    = 4;
   localparam int DELAY_W   = 24;
   localparam int JITTER_W  = 24;
   localparam int RANDOM_W  = 32;
   localparam int COUNT_W   = 16;
   localparam int RDELAY_W  = 25;
   localparam int ECOUNT_W  = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_QUERY        = 4'd0,
      MODE_INCREASE     = 4'd1,
      MODE_SET_COUNT    = 4'd2,
      MODE_SET_CUR_MAX  = 4'd3,
      MODE_RESTORE_MAX  = 4'd4,
      MODE_SET_FOREVER  = 4'd5,
      MODE_RESET        = 4'd6,
      MODE_FOREVER_LAST = 4'd7,
      MODE_LOAD_ENTRY   = 4'd8
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RETRY_LIMIT = 1'd0,
      CSR_ENTRY_COUNT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [DELAY_W-1:0]  delay;
      logic [JITTER_W-1:0] jitter;
   } entry_type;

endpackage

>>> rtl/rbs_if.sv
// Request and response channel interfaces of the retry backoff scheduler.
interface rbs_req_if;
   import rbs_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic signed [VALUE_W-1:0] value;
   logic                forever_flag;
   logic [SLOT_W-1:0]   entry_index;
   logic [DELAY_W-1:0]  entry_delay;
   logic [JITTER_W-1:0] entry_jitter;
   logic [RANDOM_W-1:0] random_word;

   modport source (
      output valid, mode, value, forever_flag, entry_index, entry_delay, entry_jitter,
             random_word,
      input  ready
   );
   modport sink (
      input  valid, mode, value, forever_flag, entry_index, entry_delay, entry_jitter,
             random_word,
      output ready
   );
endinterface

interface rbs_rsp_if;
   import rbs_pkg::*;

   logic                valid;
   logic                ready;
   logic                retry_needed;
   logic [RDELAY_W-1:0] retry_delay;
   logic [COUNT_W-1:0]  retry_count;
   logic                retry_forever;

   modport source (
      output valid, retry_needed, retry_delay, retry_count, retry_forever,
      input  ready
   );
   modport sink (
      input  valid, retry_needed, retry_delay, retry_count, retry_forever,
      output ready
   );
endinterface

>>> rtl/retry_backoff_scheduler_unit.sv
// Top level of the retry backoff scheduler.
//
// Usage:
//   req channel: one command transaction (mode, value, flag, table entry, random word).
//   rsp channel: one result transaction per command (retry needed, delay, count, flag).
//   csr port: csr_we with csr_index 0 writes the retry limit, index 1 writes entry_count.
//   Write the csr registers only while no command is in flight.
// Pipeline: two register stages, the first loaded at the edge that accepts a command
//   and the second, which holds the result, loaded from the first.
// Throughput: one command per cycle while rsp is not held off. The count, maximum
//   and flag update in the accept cycle; the delay table read is registered, and
//   the 32x24 jitter multiply plus add fills the second stage.
// Reset: synchronous, clears count, current maximum, forever flag, csr registers
//   and all valid flags. Delay table contents are undefined until loaded.
// Stall: when rsp is held off with a result waiting, the whole pipeline holds and
//   req.ready drops; it rises again in the cycle rsp.ready returns.
module retry_backoff_scheduler_unit #(
   parameter int TABLE_DEPTH = rbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   rbs_req_if.sink                               req,
   rbs_rsp_if.source                             rsp,
   input  logic                                  csr_we,
   input  logic [rbs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rbs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import rbs_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SZ_W  = $clog2(TABLE_DEPTH + 1);

   // csr registers
   logic [COUNT_W-1:0]  retry_limit_ff;
   logic [ECOUNT_W-1:0] entry_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= '0;
         entry_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[COUNT_W-1:0];
            CSR_ENTRY_COUNT: entry_count_ff <= csr_wdata[ECOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic out_valid_ff;
   logic s1_valid_ff;
   logic advance;
   logic accept;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   // state update
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] cur_max_ff, cur_max_in;
   logic               forever_ff, forever_in;
   logic [COUNT_W-1:0] clamped;
   logic [COUNT_W:0]   count_inc;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_entry;

   assign clamped   = req.value[VALUE_W-1] ? '0 : req.value[COUNT_W-1:0];
   assign count_inc = {1'b0, count_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign wr_addr   = IDX_W'(req.entry_index);
   assign wr_entry  = '{delay: req.entry_delay, jitter: req.entry_jitter};

   always_comb begin
      count_in   = count_ff;
      cur_max_in = cur_max_ff;
      forever_in = forever_ff;
      wr_en      = 1'b0;
      case (mode_type'(req.mode))
         MODE_INCREASE: begin
            count_in = (count_inc > {1'b0, cur_max_ff}) ? cur_max_ff
                                                         : count_inc[COUNT_W-1:0];
         end
         MODE_SET_COUNT: begin
            count_in = (clamped > cur_max_ff) ? cur_max_ff : clamped;
         end
         MODE_SET_CUR_MAX: begin
            cur_max_in = clamped;
            count_in   = (count_ff > clamped) ? clamped : count_ff;
         end
         MODE_RESTORE_MAX: begin
            cur_max_in = retry_limit_ff;
            count_in   = (count_ff > retry_limit_ff) ? retry_limit_ff : count_ff;
         end
         MODE_SET_FOREVER: begin
            forever_in = req.forever_flag;
         end
         MODE_RESET: begin
            count_in = '0;
         end
         MODE_FOREVER_LAST: begin
            count_in   = cur_max_ff;
            forever_in = 1'b1;
         end
         MODE_LOAD_ENTRY: begin
            wr_en = accept && (32'(req.entry_index) < TABLE_DEPTH);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cur_max_ff <= '0;
         forever_ff <= 1'b0;
      end else if (accept) begin
         count_ff   <= count_in;
         cur_max_ff <= cur_max_in;
         forever_ff <= forever_in;
      end
   end

   // table index from the updated count; entries past the table use the last one
   logic [SZ_W-1:0]  size_c;
   logic [IDX_W-1:0] rd_idx;

   assign size_c = (32'(entry_count_ff) > TABLE_DEPTH) ? SZ_W'(TABLE_DEPTH)
                                                       : SZ_W'(entry_count_ff);
   assign rd_idx = (32'(count_in) < 32'(size_c)) ? IDX_W'(count_in)
                                                 : IDX_W'(size_c - SZ_W'(1));

   // delay table
   entry_type table_ff [TABLE_DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_entry_ff <= table_ff[rd_idx];
      end
   end

   // stage 1 registers
   logic                s1_needed_ff;
   logic [COUNT_W-1:0]  s1_count_ff;
   logic                s1_forever_ff;
   logic                s1_empty_ff;
   logic [RANDOM_W-1:0] s1_random_ff;
   logic                s1_bypass_ff;
   entry_type           s1_wr_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_needed_ff   <= forever_in || (count_in < cur_max_in);
         s1_count_ff    <= count_in;
         s1_forever_ff  <= forever_in;
         s1_empty_ff    <= (size_c == '0);
         s1_random_ff   <= req.random_word;
         // write in the same cycle as the read: take the new entry
         s1_bypass_ff   <= wr_en && (wr_addr == rd_idx);
         s1_wr_entry_ff <= wr_entry;
      end
   end

   // stage 2: jitter draw and delay sum
   entry_type                    sel_entry;
   logic [RANDOM_W+JITTER_W-1:0] product;
   logic [RDELAY_W-1:0]          delay_sum;

   assign sel_entry = s1_bypass_ff ? s1_wr_entry_ff : rd_entry_ff;
   assign product   = {{JITTER_W{1'b0}}, s1_random_ff}
                    * {{RANDOM_W{1'b0}}, sel_entry.jitter};
   assign delay_sum = s1_empty_ff ? '0
                    : {1'b0, sel_entry.delay}
                      + {1'b0, product[RANDOM_W+JITTER_W-1:RANDOM_W]};

   logic                needed_ff;
   logic [RDELAY_W-1:0] delay_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_forever_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         needed_ff      <= s1_needed_ff;
         delay_ff       <= delay_sum;
         out_count_ff   <= s1_count_ff;
         out_forever_ff <= s1_forever_ff;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.retry_needed  = needed_ff;
   assign rsp.retry_delay   = delay_ff;
   assign rsp.retry_count   = out_count_ff;
   assign rsp.retry_forever = out_forever_ff;

endmodule

>>> rtl/rbs_checker.sv
// Port-level assertions for the retry backoff scheduler, bound to the top level.
module rbs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_retry_needed,
   input logic [rbs_pkg::RDELAY_W-1:0] rsp_retry_delay,
   input logic [rbs_pkg::COUNT_W-1:0]  rsp_retry_count,
   input logic                         rsp_retry_forever
);
   import rbs_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_retry_delay)
         && $stable(rsp_retry_count) && $stable(rsp_retry_forever)
         && $stable(rsp_retry_needed))
      else $error("rsp payload changed while stalled");

   // forever flag always implies a retry is needed
   a_forever_needed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_retry_forever |-> rsp_retry_needed)
      else $error("forever set without retry_needed");

   // no command is taken while a result is blocked
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req accepted while rsp stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind retry_backoff_scheduler_unit rbs_checker u_rbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_retry_needed  (rsp.retry_needed),
   .rsp_retry_delay   (rsp.retry_delay),
   .rsp_retry_count   (rsp.retry_count),
   .rsp_retry_forever (rsp.retry_forever)
);
